// ===== rtl/core/pcfm_pkg.sv =====
// Shared widths, register indexes and constants of the pulse counter frequency meter.
package pcfm_pkg;

	localparam int COUNT_W   = 20;
	localparam int ELAPSED_W = 16;
	localparam int FREQ_W    = 40;
	localparam int HALF_W    = FREQ_W / 2;
	localparam int GAIN_W    = 32;
	localparam int ROLL_W    = COUNT_W + 1;
	localparam int OUT_W     = 48;
	localparam int PROD_W    = HALF_W + 1 + GAIN_W;

	// delta * 1000 ms/s * 256 (Q.8)
	localparam int FREQ_SCALE = 256000;
	localparam int DIVD_W     = COUNT_W + 18;
	localparam int DCNT_W     = $clog2(DIVD_W);

	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 32;

	localparam logic [CFG_IDX_W-1:0] REG_ROLLOVER     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_GAIN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_OFFSET = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FREQ_GAIN    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FREQ_OFFSET  = 3'd4;

	localparam logic [ROLL_W-1:0] ROLLOVER_RST = ROLL_W'(1000000);
	localparam logic [GAIN_W-1:0] GAIN_ONE     = GAIN_W'(65536);
	localparam logic signed [OUT_W-1:0] NO_FREQ_Q8 = -OUT_W'(25856);

	localparam logic kind_edge = 1'b0;
	localparam logic kind_gate = 1'b1;

endpackage

// ===== rtl/core/pcfm_item_if.sv =====
// Request channels of the pulse counter frequency meter: input items and results.
interface pcfm_item_if
	import pcfm_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic                 kind;
	logic [ELAPSED_W-1:0] elapsed_ms;

	modport source (output valid, kind, elapsed_ms, input ready);
	modport sink (input valid, kind, elapsed_ms, output ready);
endinterface

interface pcfm_result_if
	import pcfm_pkg::*;
;
	logic                    valid;
	logic                    ready;
	logic [COUNT_W-1:0]      raw_count;
	logic                    feedback_level;
	logic [FREQ_W-1:0]       frequency_q8;
	logic                    freq_valid;
	logic signed [OUT_W-1:0] scaled_count;
	logic signed [OUT_W-1:0] scaled_frequency;
	logic                    div_error;

	modport source (output valid, raw_count, feedback_level, frequency_q8, freq_valid,
		scaled_count, scaled_frequency, div_error, input ready);
	modport sink (input valid, raw_count, feedback_level, frequency_q8, freq_valid,
		scaled_count, scaled_frequency, div_error, output ready);
endinterface

// ===== rtl/core/pulse_counter_frequency_meter_core.sv =====
// Pulse counter frequency meter: counter, bit-serial gate divider and scaling datapath.
// One request at a time, one result per request. An edge request runs accept, count
// multiply and finish; a gate end with zero elapsed time runs the same steps.
// A gate end with elapsed time first runs the restoring divider, which retires
// one quotient bit per cycle, and then the frequency rescale (MFL, MFH, MSUM, FSAT).
// The rescale steps also run on the first request after reset and on the first
// request after a write of freq_gain or freq_offset. All products go through one
// shared 21x32 signed multiplier; the 40-bit frequency is multiplied as two 20-bit
// halves. The output register lets a new request be accepted while the previous
// result still waits to be taken.
module pulse_counter_frequency_meter_core
	import pcfm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata,
	pcfm_item_if.sink            items,
	pcfm_result_if.source        results
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_MULC = 3'd2;
	localparam logic [2:0] S_MFL  = 3'd3;
	localparam logic [2:0] S_MFH  = 3'd4;
	localparam logic [2:0] S_MSUM = 3'd5;
	localparam logic [2:0] S_FSAT = 3'd6;
	localparam logic [2:0] S_FIN  = 3'd7;

	logic [2:0] state_q;

	logic [ROLL_W-1:0]       rollover_q;
	logic signed [GAIN_W-1:0] cgain_q, coff_q, fgain_q, foff_q;

	logic [COUNT_W-1:0] count_q, snap_q;
	logic [FREQ_W-1:0]  freq_q;
	logic               seen_q, dirty_q, derr_q;

	logic [DIVD_W-1:0]    dq_q;
	logic [ELAPSED_W-1:0] rem_q, ms_q;
	logic [DCNT_W-1:0]    dcnt_q;

	logic signed [PROD_W-1:0]      cprod_q, flo_q, fhi_q;
	logic signed [PROD_W+19-16:0]  fsh_q;
	logic signed [OUT_W-1:0]       sfreq_q;

	logic out_valid_q;
	logic out_free;
	logic accept;

	// next count and gate delta
	logic [ROLL_W-1:0]  cnt_inc;
	logic [ROLL_W-1:0]  modulus;
	logic [ROLL_W:0]    wrap_sum;
	logic [COUNT_W-1:0] delta;
	logic [DIVD_W-1:0]  dividend;

	// divider step
	logic [ELAPSED_W:0] trial, trial_diff;
	logic               trial_ge;

	// shared multiplier
	logic signed [HALF_W:0]   mul_a;
	logic signed [GAIN_W-1:0] mul_b;
	logic signed [PROD_W-1:0] mul_p;

	logic signed [PROD_W+19:0] facc;
	logic signed [OUT_W+9:0]   fdiff;
	logic signed [OUT_W-1:0]   sc_w;

	assign out_free    = !out_valid_q || results.ready;
	assign items.ready = (state_q == S_IDLE);
	assign accept      = items.valid && items.ready;

	assign cnt_inc  = ROLL_W'(count_q) + ROLL_W'(1);
	assign modulus  = (rollover_q == '0 || rollover_q > ROLL_W'(1 << COUNT_W))
		? ROLL_W'(1 << COUNT_W) : rollover_q;
	assign wrap_sum = (ROLL_W+1)'(count_q) + (ROLL_W+1)'(modulus) - (ROLL_W+1)'(snap_q);
	assign delta    = (count_q >= snap_q) ? (count_q - snap_q) : wrap_sum[COUNT_W-1:0];
	assign dividend = DIVD_W'(delta) * DIVD_W'(FREQ_SCALE);

	assign trial      = {rem_q, dq_q[DIVD_W-1]};
	assign trial_ge   = trial >= {1'b0, ms_q};
	assign trial_diff = trial - {1'b0, ms_q};

	always_comb begin
		mul_a = $signed({1'b0, count_q});
		mul_b = cgain_q;
		case (state_q)
			S_MFL: begin
				mul_a = $signed({1'b0, freq_q[HALF_W-1:0]});
				mul_b = fgain_q;
			end
			S_MFH: begin
				mul_a = $signed({1'b0, freq_q[FREQ_W-1:HALF_W]});
				mul_b = fgain_q;
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// floor division by 2^16 is the arithmetic shift of the signed product
	assign facc  = $signed({fhi_q, HALF_W'(0)}) + (PROD_W+20)'(flo_q);
	assign fdiff = (OUT_W+10)'(fsh_q) - (OUT_W+10)'(foff_q);
	assign sc_w  = OUT_W'($signed(cprod_q[PROD_W-1:8])) - OUT_W'(coff_q);

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rollover_q  <= ROLLOVER_RST;
			cgain_q     <= GAIN_ONE;
			coff_q      <= '0;
			fgain_q     <= GAIN_ONE;
			foff_q      <= '0;
			count_q     <= '0;
			snap_q      <= '0;
			freq_q      <= '0;
			seen_q      <= 1'b0;
			dirty_q     <= 1'b1;
			derr_q      <= 1'b0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				unique case (cfg_idx)
					REG_ROLLOVER:     rollover_q <= cfg_wdata[ROLL_W-1:0];
					REG_COUNT_GAIN:   cgain_q    <= cfg_wdata;
					REG_COUNT_OFFSET: coff_q     <= cfg_wdata;
					REG_FREQ_GAIN: begin
						fgain_q <= cfg_wdata;
						dirty_q <= 1'b1;
					end
					REG_FREQ_OFFSET: begin
						foff_q  <= cfg_wdata;
						dirty_q <= 1'b1;
					end
					default: ;
				endcase
			end

			if (results.ready && !(state_q == S_FIN && out_free))
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						derr_q <= 1'b0;
						if (items.kind == kind_edge) begin
							count_q <= (cnt_inc >= rollover_q || cnt_inc[COUNT_W])
								? '0 : cnt_inc[COUNT_W-1:0];
							state_q <= S_MULC;
						end else begin
							snap_q <= count_q;
							if (items.elapsed_ms == '0) begin
								derr_q  <= 1'b1;
								state_q <= S_MULC;
							end else begin
								dcnt_q  <= '0;
								state_q <= S_DIV;
							end
						end
					end
				end
				S_DIV: begin
					dcnt_q <= dcnt_q + DCNT_W'(1);
					if (dcnt_q == DCNT_W'(DIVD_W - 1)) begin
						// quotient stays below 2^38, no saturation needed
						freq_q  <= FREQ_W'({dq_q[DIVD_W-2:0], trial_ge});
						seen_q  <= 1'b1;
						dirty_q <= 1'b1;
						state_q <= S_MULC;
					end
				end
				S_MULC:  state_q <= dirty_q ? S_MFL : S_FIN;
				S_MFL:   state_q <= S_MFH;
				S_MFH:   state_q <= S_MSUM;
				S_MSUM:  state_q <= S_FSAT;
				S_FSAT: begin
					dirty_q <= 1'b0;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept && items.kind == kind_gate) begin
			dq_q  <= dividend;
			rem_q <= '0;
			ms_q  <= items.elapsed_ms;
		end else if (state_q == S_DIV) begin
			dq_q  <= {dq_q[DIVD_W-2:0], trial_ge};
			rem_q <= trial_ge ? trial_diff[ELAPSED_W-1:0] : trial[ELAPSED_W-1:0];
		end

		if (state_q == S_MULC)
			cprod_q <= mul_p;
		if (state_q == S_MFL)
			flo_q <= mul_p;
		if (state_q == S_MFH)
			fhi_q <= mul_p;
		if (state_q == S_MSUM)
			fsh_q <= facc[PROD_W+19:16];
		if (state_q == S_FSAT) begin
			if (fdiff[OUT_W+9:OUT_W-1] == {11{fdiff[OUT_W+9]}})
				sfreq_q <= fdiff[OUT_W-1:0];
			else
				sfreq_q <= fdiff[OUT_W+9] ? {1'b1, (OUT_W-1)'(0)} : {1'b0, {(OUT_W-1){1'b1}}};
		end

		if (state_q == S_FIN && out_free) begin
			results.raw_count        <= count_q;
			results.feedback_level   <= count_q[0];
			results.frequency_q8     <= freq_q;
			results.freq_valid       <= seen_q;
			results.scaled_count     <= sc_w;
			results.scaled_frequency <= seen_q ? sfreq_q : NO_FREQ_Q8;
			results.div_error        <= derr_q;
		end
	end

	assign results.valid = out_valid_q;

	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !items.ready)
		else $error("input taken while a request is in progress");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (ms_q != '0))
		else $error("divider running with zero divisor");

	a_seen_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q |=> seen_q)
		else $error("frequency valid flag dropped");

	a_fin_from_scale: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && $past(state_q) != S_FIN) |-> !dirty_q)
		else $error("result formed from stale frequency scaling");

endmodule
